/* hdl/lzw_byte_encoder_macros.svh */
// Assertion macros used by the checker file of the LZW byte encoder.
// Each macro states one clocked property that is disabled while reset is low.
`ifndef LZW_BYTE_ENCODER_MACROS_SVH
`define LZW_BYTE_ENCODER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define LZWBE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define LZWBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lzwbe_pkg.sv */
// ----------------------------------------------------------------------------
// lzwbe_pkg
// Shared constants and controller/datapath interface types for the LZW
// byte encoder.
// ----------------------------------------------------------------------------
package lzwbe_pkg;

    // Dictionary size; codes stop at the smaller of this and 4096.
    localparam int DICT_SIZE = 4096;

    localparam int CODE_W = 12;
    localparam int BYTE_W = 8;
    localparam int KEY_W  = CODE_W + BYTE_W;
    localparam int NFC_W  = 13;
    localparam int FWID_W = 4;

    localparam logic [NFC_W-1:0] FIRST_CODE = 13'd256;
    localparam logic [NFC_W-1:0] CODE_CAP   =
        (DICT_SIZE < 4096) ? NFC_W'(DICT_SIZE) : 13'd4096;

    // Open-addressed hash table of (prefix, byte) -> code.
    localparam int SLOT_AW = 13;
    localparam int SLOTS   = 1 << SLOT_AW;

    // Epoch tags mark which slots belong to the current stream. Tag zero is
    // the cleared value and never matches a live epoch.
    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } lzwbe_slot_t;

    typedef struct packed {
        logic load_item;     // latch the accepted byte and its hash index
        logic start_prefix;  // first byte of a stream becomes the prefix
        logic take_hit;      // prefix takes the matched slot's code
        logic step_index;    // probe the next slot
        logic emit_miss;     // emit prefix, learn the pair if codes remain, restart from byte
        logic emit_last;     // emit final code and restart the dictionary
        logic clear_write;   // clearing pass writes one slot
    } lzwbe_cmd_t;

    typedef struct packed {
        logic prefix_valid;
        logic slot_empty;
        logic slot_hit;
        logic out_free;
        logic eos;
        logic epoch_wrap;
        logic clear_done;
    } lzwbe_status_t;

endpackage

/* hdl/lzwbe_ctrl.sv */
// ----------------------------------------------------------------------------
// lzwbe_ctrl
// Sequencer of the LZW byte encoder: input handshake, probe loop, emission
// and the slot clearing pass.
// ----------------------------------------------------------------------------
module lzwbe_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    input  logic                    end_of_stream,
    output logic                    byte_ready,
    input  lzwbe_pkg::lzwbe_status_t status,
    output lzwbe_pkg::lzwbe_cmd_t    cmd
);
    import lzwbe_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_MISS,
        ST_LAST
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        byte_ready = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                byte_ready = 1'b1;
                if (byte_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (!status.prefix_valid)
                    begin
                        cmd.start_prefix = 1'b1;
                        state_next = end_of_stream ? ST_LAST : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                priority if (status.slot_hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next = status.eos ? ST_LAST : ST_IDLE;
                end
                else if (status.slot_empty)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    cmd.step_index = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_MISS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next = status.eos ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next = status.epoch_wrap ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/lzwbe_datapath.sv */
// ----------------------------------------------------------------------------
// lzwbe_datapath
// Prefix and code counter registers, the hashed dictionary memory with its
// epoch tags, and the output register.
// ----------------------------------------------------------------------------
module lzwbe_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_stream,
    input  logic                     code_ready,
    input  lzwbe_pkg::lzwbe_cmd_t    cmd,
    output lzwbe_pkg::lzwbe_status_t status,
    output logic                     code_valid,
    output logic [11:0]              code,
    output logic [3:0]               final_width,
    output logic                     last_code
);
    import lzwbe_pkg::*;

    // Spread the byte over the high index bits so that strings sharing a
    // prefix land far apart.
    function automatic logic [SLOT_AW-1:0] slot_hash(input logic [KEY_W-1:0] key);
        slot_hash = {key[BYTE_W-1:0], key[SLOT_AW-1:BYTE_W]} ^ {1'b0, key[KEY_W-1:BYTE_W]};
    endfunction

    function automatic logic [FWID_W-1:0] width_of(input logic [NFC_W-1:0] nfc);
        if (nfc < 13'd512)
            width_of = 4'd9;
        else if (nfc < 13'd1024)
            width_of = 4'd10;
        else if (nfc < 13'd2048)
            width_of = 4'd11;
        else
            width_of = 4'd12;
    endfunction

    lzwbe_slot_t slot_mem [SLOTS];

    logic [CODE_W-1:0]  prefix_reg, prefix_next;
    logic               pv_reg, pv_next;
    logic [NFC_W-1:0]   nfc_reg, nfc_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               eos_reg, eos_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_AW-1:0] idx_reg, idx_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [SLOT_AW-1:0] clr_cnt_reg, clr_cnt_next;
    lzwbe_slot_t        rdata_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [FWID_W-1:0]  width_reg, width_next;
    logic               last_reg, last_next;

    logic               learn;
    logic               mem_we;
    logic [SLOT_AW-1:0] mem_waddr;
    lzwbe_slot_t        mem_wdata;
    logic [KEY_W-1:0]   in_key;

    assign in_key = {prefix_reg, data_byte};
    assign learn  = cmd.emit_miss && (nfc_reg < CODE_CAP);

    assign status.prefix_valid = pv_reg;
    assign status.slot_empty   = rdata_reg.tag != epoch_reg;
    assign status.slot_hit     = (rdata_reg.tag == epoch_reg) && (rdata_reg.key == key_reg);
    assign status.out_free     = !out_valid_reg || code_ready;
    assign status.eos          = eos_reg;
    assign status.epoch_wrap   = epoch_reg == EPOCH_MAX;
    assign status.clear_done   = &clr_cnt_reg;

    assign code_valid  = out_valid_reg;
    assign code        = code_reg;
    assign final_width = width_reg;
    assign last_code   = last_reg;

    always_comb
    begin
        prefix_next    = prefix_reg;
        pv_next        = pv_reg;
        nfc_next       = nfc_reg;
        byte_next      = byte_reg;
        eos_next       = eos_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        epoch_next     = epoch_reg;
        clr_cnt_next   = clr_cnt_reg;
        code_next      = code_reg;
        width_next     = width_reg;
        last_next      = last_reg;
        out_valid_next = code_ready ? 1'b0 : out_valid_reg;

        if (cmd.load_item)
        begin
            byte_next = data_byte;
            eos_next  = end_of_stream;
            key_next  = in_key;
            idx_next  = slot_hash(in_key);
        end
        if (cmd.start_prefix)
        begin
            prefix_next = CODE_W'(data_byte);
            pv_next     = 1'b1;
        end
        if (cmd.take_hit)
        begin
            prefix_next = rdata_reg.code;
        end
        if (cmd.step_index)
        begin
            idx_next = idx_reg + SLOT_AW'(1);
        end
        if (cmd.emit_miss)
        begin
            out_valid_next = 1'b1;
            code_next      = prefix_reg;
            width_next     = '0;
            last_next      = 1'b0;
            prefix_next    = CODE_W'(byte_reg);
            if (learn)
            begin
                nfc_next = nfc_reg + NFC_W'(1);
            end
        end
        if (cmd.emit_last)
        begin
            out_valid_next = 1'b1;
            code_next      = prefix_reg;
            width_next     = width_of(nfc_reg);
            last_next      = 1'b1;
            nfc_next       = FIRST_CODE;
            prefix_next    = '0;
            pv_next        = 1'b0;
            epoch_next     = (epoch_reg == EPOCH_MAX) ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
        end
        if (cmd.clear_write)
        begin
            clr_cnt_next = clr_cnt_reg + SLOT_AW'(1);
        end
    end

    always_comb
    begin
        mem_we    = learn || cmd.clear_write;
        mem_waddr = cmd.clear_write ? clr_cnt_reg : idx_reg;
        if (cmd.clear_write)
        begin
            mem_wdata = '0;
        end
        else
        begin
            mem_wdata.tag  = epoch_reg;
            mem_wdata.key  = key_reg;
            mem_wdata.code = nfc_reg[CODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            pv_reg        <= 1'b0;
            nfc_reg       <= FIRST_CODE;
            eos_reg       <= 1'b0;
            epoch_reg     <= EPOCH_FIRST;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prefix_reg    <= prefix_next;
            pv_reg        <= pv_next;
            nfc_reg       <= nfc_next;
            eos_reg       <= eos_next;
            epoch_reg     <= epoch_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        code_reg  <= code_next;
        width_reg <= width_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= slot_mem[idx_reg];
    end

endmodule

/* hdl/lzw_byte_encoder.sv */
// The first byte of a stream is taken straight into the prefix; any other byte
// goes through a read and a compare state, again for each extra hash probe, and a
// miss state on a miss. A final byte adds a last state for the last code; a
// stalled output adds its wait. No new byte is taken until the last one is done.
// Reset is asynchronous, active low; afterwards a clearing pass over all 8192
// slots runs with byte_ready low, and again after every 15th stream.
// ----------------------------------------------------------------------------
// lzw_byte_encoder
// LZW compressor taking one byte per item and producing 12-bit codes.
// ----------------------------------------------------------------------------
module lzw_byte_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        code_valid,
    input  logic        code_ready,
    output logic [11:0] code,
    output logic [3:0]  final_width,
    output logic        last_code
);
    import lzwbe_pkg::*;

    // The dictionary is a hash table of 8192 slots, each holding a
    // (prefix, byte) key, the code learned for it and an epoch tag. A slot is
    // live only when its tag equals the current epoch, so restarting the
    // dictionary at the end of a stream is just an epoch increment. When the
    // epoch runs out of values, every tag is swept back to zero.
    //
    // Each byte after the first of a stream is hashed with the current prefix
    // and probed linearly: a read state fetches a slot, a compare state checks it. A live
    // slot with the same key is a hit and its code becomes the prefix. A slot
    // that is not live ends the search: the prefix is emitted, the pair is
    // written into that slot when codes remain, and the byte becomes the
    // prefix. The table never holds more than 3840 live slots, so a search
    // always ends.
    //
    // Results sit in a single output register; the controller waits in its
    // emit states until that register is free.

    lzwbe_cmd_t    cmd;
    lzwbe_status_t status;

    lzwbe_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .end_of_stream (end_of_stream),
        .byte_ready    (byte_ready),
        .status        (status),
        .cmd           (cmd)
    );

    lzwbe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .code_ready    (code_ready),
        .cmd           (cmd),
        .status        (status),
        .code_valid    (code_valid),
        .code          (code),
        .final_width   (final_width),
        .last_code     (last_code)
    );

endmodule

/* hdl/lzwbe_checker.sv */
// ----------------------------------------------------------------------------
// lzwbe_checker
// Port-level assertions for the LZW byte encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_byte_encoder_macros.svh"

module lzwbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_ready,
    input logic        end_of_stream,
    input logic        code_valid,
    input logic        code_ready,
    input logic [11:0] code,
    input logic [3:0]  final_width,
    input logic        last_code
);

    // A stalled result keeps its fields.
    `LZWBE_ASSERT_NEXT(a_out_hold, clk, rst_n, code_valid && !code_ready, code_valid && $stable(code) && $stable(final_width) && $stable(last_code), "stalled code changed")

    // The last code of a stream carries a width of 9 to 12 bits.
    `LZWBE_ASSERT_IMPL(a_last_width, clk, rst_n, code_valid && last_code, final_width == 4'd9 || final_width == 4'd10 || final_width == 4'd11 || final_width == 4'd12, "bad final width")

    // Codes that are not last carry no width.
    `LZWBE_ASSERT_IMPL(a_mid_width, clk, rst_n, code_valid && !last_code, final_width == 4'd0, "width on a code that is not last")

    // A final byte always leads to work before the next byte is taken.
    `LZWBE_ASSERT_NEXT(a_eos_busy, clk, rst_n, byte_valid && byte_ready && end_of_stream, !byte_ready, "byte taken right after a final byte")

endmodule

bind lzw_byte_encoder lzwbe_checker u_lzwbe_checker (.*);
